// File: hdl/servo_write_packet_framer_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef SERVO_WRITE_PACKET_FRAMER_UNIT_MACROS_SVH
`define SERVO_WRITE_PACKET_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define SWPF_ASSERT_NOW(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("swpf check failed: same-cycle rule");

// Next-cycle implication, quiet while reset is held.
`define SWPF_ASSERT_NEXT(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("swpf check failed: next-cycle rule");

`endif

// File: hdl/swpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swpf_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int IDX_W      = 4;
  localparam int BIT_CNT_W  = 3;
  localparam int IN_TDATA_W = BYTE_W + WORD_W + WORD_W;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  localparam byte_t HDR_SYNC    = 8'hFF;
  localparam byte_t HDR_MARK    = 8'hFD;
  localparam byte_t HDR_RSVD    = 8'h00;
  localparam byte_t INSTR_WRITE = 8'h03;
  localparam byte_t LEN_ONE     = 8'h06;
  localparam byte_t LEN_TWO     = 8'h07;
  localparam byte_t LEN_HI      = 8'h00;
  localparam word_t CRC_POLY    = 16'h8005;

  // Byte positions of the packet body ahead of the CRC.
  localparam idx_t IDX_SYNC0   = 4'd0;
  localparam idx_t IDX_SYNC1   = 4'd1;
  localparam idx_t IDX_MARK    = 4'd2;
  localparam idx_t IDX_RSVD    = 4'd3;
  localparam idx_t IDX_ID      = 4'd4;
  localparam idx_t IDX_LEN_LO  = 4'd5;
  localparam idx_t IDX_LEN_HI  = 4'd6;
  localparam idx_t IDX_INSTR   = 4'd7;
  localparam idx_t IDX_ADDR_LO = 4'd8;
  localparam idx_t IDX_ADDR_HI = 4'd9;
  localparam idx_t IDX_VAL_LO  = 4'd10;
  localparam idx_t IDX_VAL_HI  = 4'd11;

  function automatic byte_t pkt_byte(idx_t idx, byte_t id, word_t addr, word_t val,
                                     logic wide);
    byte_t b;
    unique case (idx)
      IDX_SYNC0:   b = HDR_SYNC;
      IDX_SYNC1:   b = HDR_SYNC;
      IDX_MARK:    b = HDR_MARK;
      IDX_RSVD:    b = HDR_RSVD;
      IDX_ID:      b = id;
      IDX_LEN_LO:  b = wide ? LEN_TWO : LEN_ONE;
      IDX_LEN_HI:  b = LEN_HI;
      IDX_INSTR:   b = INSTR_WRITE;
      IDX_ADDR_LO: b = addr[BYTE_W-1:0];
      IDX_ADDR_HI: b = addr[WORD_W-1:BYTE_W];
      IDX_VAL_LO:  b = val[BYTE_W-1:0];
      IDX_VAL_HI:  b = val[WORD_W-1:BYTE_W];
      default:     b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/servo_write_packet_framer_unit.sv
// Register-write packet framer. Each input request (servo id, 16-bit register
// address, value, width flag) becomes one packet on the output byte stream:
// FF FF FD 00, id, length (06 or 07) LSB first, instruction 03, address LSB
// first, one or two value bytes LSB first, then a CRC-16 (poly 0x8005, init 0,
// non-reflected) LSB first, with tlast on the CRC high byte. A one-byte request
// gives 13 output bytes, a two-byte request 14. The CRC runs bit-serially, one
// bit per clock: each body byte is loaded into the output register and shift
// register once the output register is free, then its eight bits are folded
// into the CRC, MSB first; the two CRC bytes follow, each offered once the
// output register is free. Body bytes appear as soon as they are loaded. The
// next request is accepted while the final CRC byte still waits in the output
// register.
`timescale 1ns / 1ps
`default_nettype none

module servo_write_packet_framer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] servo_id, [23:8] reg_address, [39:24] write_value
  input  wire logic [swpf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] two_byte_value
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] tx_byte
  output logic [swpf_pkg::BYTE_W-1:0]              out_tdata,
  output logic                                     out_tlast
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_BITS   = 3'd2;
  localparam logic [2:0] ST_CRC_LO = 3'd3;
  localparam logic [2:0] ST_CRC_HI = 3'd4;

  localparam swpf_pkg::bit_cnt_t BIT_LAST = swpf_pkg::bit_cnt_t'(swpf_pkg::BYTE_W - 1);

  // Control state
  logic [2:0]             state_r, state_nxt;
  swpf_pkg::idx_t         idx_r, idx_nxt;
  swpf_pkg::bit_cnt_t     bitcnt_r, bitcnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Payload
  swpf_pkg::byte_t        id_r, id_nxt;
  swpf_pkg::word_t        addr_r, addr_nxt;
  swpf_pkg::word_t        val_r, val_nxt;
  logic                   wide_r, wide_nxt;
  swpf_pkg::byte_t        sh_r, sh_nxt;
  swpf_pkg::word_t        crc_r, crc_nxt;
  swpf_pkg::byte_t        out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   slot_free;
  logic                   fb;
  swpf_pkg::word_t        crc_step;
  swpf_pkg::byte_t        cur_byte;
  swpf_pkg::idx_t         last_idx;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_tready;

  // One CRC bit per clock, MSB of the byte first.
  assign fb       = crc_r[swpf_pkg::WORD_W-1] ^ sh_r[swpf_pkg::BYTE_W-1];
  assign crc_step = {crc_r[swpf_pkg::WORD_W-2:0], 1'b0} ^ (fb ? swpf_pkg::CRC_POLY : '0);

  assign cur_byte = swpf_pkg::pkt_byte(idx_r, id_r, addr_r, val_r, wide_r);
  assign last_idx = wide_r ? swpf_pkg::IDX_VAL_HI : swpf_pkg::IDX_VAL_LO;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    bitcnt_nxt    = bitcnt_r;
    id_nxt        = id_r;
    addr_nxt      = addr_r;
    val_nxt       = val_r;
    wide_nxt      = wide_r;
    sh_nxt        = sh_r;
    crc_nxt       = crc_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    // Drop the held byte once the sink takes it.
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          id_nxt    = in_tdata[swpf_pkg::BYTE_W-1:0];
          addr_nxt  = in_tdata[swpf_pkg::BYTE_W +: swpf_pkg::WORD_W];
          val_nxt   = in_tdata[swpf_pkg::BYTE_W + swpf_pkg::WORD_W +: swpf_pkg::WORD_W];
          wide_nxt  = in_tuser;
          idx_nxt   = swpf_pkg::IDX_SYNC0;
          crc_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Offer the body byte and start folding it into the CRC.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cur_byte;
          out_last_nxt  = 1'b0;
          sh_nxt        = cur_byte;
          bitcnt_nxt    = '0;
          state_nxt     = ST_BITS;
        end
      end
      ST_BITS: begin
        crc_nxt    = crc_step;
        sh_nxt     = {sh_r[swpf_pkg::BYTE_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 1'b1;
        if (bitcnt_r == BIT_LAST) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_r == last_idx) ? ST_CRC_LO : ST_LOAD;
        end
      end
      ST_CRC_LO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = crc_r[swpf_pkg::BYTE_W-1:0];
          out_last_nxt  = 1'b0;
          state_nxt     = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = crc_r[swpf_pkg::WORD_W-1:swpf_pkg::BYTE_W];
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      bitcnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      bitcnt_r    <= bitcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    addr_r     <= addr_nxt;
    val_r      <= val_nxt;
    wide_r     <= wide_nxt;
    sh_r       <= sh_nxt;
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/swpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "servo_write_packet_framer_unit_macros.svh"

module swpf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [swpf_pkg::BYTE_W-1:0]     out_tdata,
  input wire logic                            out_tlast
);

  // A stalled output byte holds its value.
  `SWPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // One request at a time: taking a request closes the input.
  `SWPF_ASSERT_NEXT(a_one_request, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // While open for a request, only a packet's final byte may still wait.
  `SWPF_ASSERT_NOW(a_idle_tail, clk, rst_n, in_tready && out_tvalid, out_tlast)

endmodule

bind servo_write_packet_framer_unit swpf_checker u_swpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
